// ===== design/cau_pkg.sv =====
// Shared widths, command codes, the divider lane record and the saturation helper.
package cau_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int NUM_BITS  = PROD_BITS + 1;
  localparam int SAT_BITS  = PROD_BITS + 2;
  localparam int QUO_BITS  = WORD_BITS;
  localparam int REM_BITS  = PROD_BITS;
  localparam int FULL_BITS = NUM_BITS + FRAC_BITS;
  localparam int DIV_CELLS = QUO_BITS;

  typedef logic [2:0] cmd_t;
  localparam cmd_t CMD_ADD  = 3'd0;
  localparam cmd_t CMD_SUB  = 3'd1;
  localparam cmd_t CMD_MUL  = 3'd2;
  localparam cmd_t CMD_DIV  = 3'd3;
  localparam cmd_t CMD_CONJ = 3'd4;
  localparam cmd_t CMD_NEG  = 3'd5;

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic                valid;
    logic                div;
    logic                dz;
    logic                ov;
    logic                neg_re;
    logic                neg_im;
    logic                big_re;
    logic                big_im;
    logic [REM_BITS-1:0] den;
    logic [REM_BITS-1:0] rem_re;
    logic [REM_BITS-1:0] rem_im;
    logic [QUO_BITS-1:0] nlo_re;
    logic [QUO_BITS-1:0] nlo_im;
    logic [QUO_BITS-1:0] q_re;
    logic [QUO_BITS-1:0] q_im;
    word_t               res_re;
    word_t               res_im;
  } lane_t;

  // returns {overflow, saturated word}
  function automatic logic [WORD_BITS:0] sat_word(input logic signed [SAT_BITS-1:0] v);
    logic [SAT_BITS-WORD_BITS:0] hi;
    hi = v[SAT_BITS-1:WORD_BITS-1];
    if ((&hi) || !(|hi)) begin
      return {1'b0, v[WORD_BITS-1:0]};
    end else if (v[SAT_BITS-1]) begin
      return {1'b1, 1'b1, {(WORD_BITS-1){1'b0}}};
    end else begin
      return {1'b1, 1'b0, {(WORD_BITS-1){1'b1}}};
    end
  endfunction

endpackage

// ===== design/cau_if.sv =====
// Operand and result channel interfaces.
interface cau_in_if;
  logic                 valid;
  logic                 ready;
  cau_pkg::cmd_t        command;
  cau_pkg::word_t       a_re;
  cau_pkg::word_t       a_im;
  cau_pkg::word_t       b_re;
  cau_pkg::word_t       b_im;
  modport source (output valid, command, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, command, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if;
  logic                 valid;
  logic                 ready;
  cau_pkg::word_t       res_re;
  cau_pkg::word_t       res_im;
  logic                 div_zero;
  logic                 overflow;
  modport source (output valid, res_re, res_im, div_zero, overflow, input ready);
  modport sink   (input valid, res_re, res_im, div_zero, overflow, output ready);
endinterface

// ===== design/cau_front.sv =====
// Front stages: products, sums and divider setup feeding the cell chain.
module cau_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  cau_pkg::cmd_t          in_cmd,
  input  cau_pkg::word_t         in_a_re,
  input  cau_pkg::word_t         in_a_im,
  input  cau_pkg::word_t         in_b_re,
  input  cau_pkg::word_t         in_b_im,
  output cau_pkg::lane_t         lane_o
);

  // stage 1: products
  logic                                  s1_valid_r;
  cau_pkg::cmd_t                         s1_cmd_r;
  cau_pkg::word_t                        s1_ar_r, s1_ai_r, s1_br_r, s1_bi_r;
  logic signed [cau_pkg::PROD_BITS-1:0]  s1_p_rr_r, s1_p_ii_r, s1_p_ri_r, s1_p_ir_r;
  logic signed [cau_pkg::PROD_BITS-1:0]  s1_d_r_r, s1_d_i_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
    end
    if (en) begin
      s1_cmd_r  <= in_cmd;
      s1_ar_r   <= in_a_re;
      s1_ai_r   <= in_a_im;
      s1_br_r   <= in_b_re;
      s1_bi_r   <= in_b_im;
      s1_p_rr_r <= in_a_re * in_b_re;
      s1_p_ii_r <= in_a_im * in_b_im;
      s1_p_ri_r <= in_a_re * in_b_im;
      s1_p_ir_r <= in_a_im * in_b_re;
      s1_d_r_r  <= in_b_re * in_b_re;
      s1_d_i_r  <= in_b_im * in_b_im;
    end
  end

  // stage 2: sums, simple results
  logic signed [cau_pkg::NUM_BITS-1:0] mul_re, mul_im, dv_re, dv_im;
  logic [cau_pkg::REM_BITS-1:0]        den;
  logic [cau_pkg::WORD_BITS:0]         sat_re, sat_im;

  always_comb begin
    mul_re = cau_pkg::NUM_BITS'(s1_p_rr_r) - cau_pkg::NUM_BITS'(s1_p_ii_r);
    mul_im = cau_pkg::NUM_BITS'(s1_p_ri_r) + cau_pkg::NUM_BITS'(s1_p_ir_r);
    dv_re  = cau_pkg::NUM_BITS'(s1_p_rr_r) + cau_pkg::NUM_BITS'(s1_p_ii_r);
    dv_im  = cau_pkg::NUM_BITS'(s1_p_ir_r) - cau_pkg::NUM_BITS'(s1_p_ri_r);
    den    = cau_pkg::REM_BITS'(s1_d_r_r) + cau_pkg::REM_BITS'(s1_d_i_r);
    sat_re = '0;
    sat_im = '0;
    case (s1_cmd_r)
      cau_pkg::CMD_ADD: begin
        sat_re = cau_pkg::sat_word(cau_pkg::SAT_BITS'(s1_ar_r) + cau_pkg::SAT_BITS'(s1_br_r));
        sat_im = cau_pkg::sat_word(cau_pkg::SAT_BITS'(s1_ai_r) + cau_pkg::SAT_BITS'(s1_bi_r));
      end
      cau_pkg::CMD_SUB: begin
        sat_re = cau_pkg::sat_word(cau_pkg::SAT_BITS'(s1_ar_r) - cau_pkg::SAT_BITS'(s1_br_r));
        sat_im = cau_pkg::sat_word(cau_pkg::SAT_BITS'(s1_ai_r) - cau_pkg::SAT_BITS'(s1_bi_r));
      end
      cau_pkg::CMD_MUL: begin
        sat_re = cau_pkg::sat_word(cau_pkg::SAT_BITS'(mul_re >>> cau_pkg::FRAC_BITS));
        sat_im = cau_pkg::sat_word(cau_pkg::SAT_BITS'(mul_im >>> cau_pkg::FRAC_BITS));
      end
      cau_pkg::CMD_CONJ: begin
        sat_re = cau_pkg::sat_word(cau_pkg::SAT_BITS'(s1_ar_r));
        sat_im = cau_pkg::sat_word(-cau_pkg::SAT_BITS'(s1_ai_r));
      end
      cau_pkg::CMD_NEG: begin
        sat_re = cau_pkg::sat_word(-cau_pkg::SAT_BITS'(s1_ar_r));
        sat_im = cau_pkg::sat_word(-cau_pkg::SAT_BITS'(s1_ai_r));
      end
      default: begin
        sat_re = '0;
        sat_im = '0;
      end
    endcase
  end

  logic                                 s2_valid_r;
  logic                                 s2_div_r;
  logic                                 s2_ov_r;
  cau_pkg::word_t                       s2_res_re_r, s2_res_im_r;
  logic signed [cau_pkg::NUM_BITS-1:0]  s2_dv_re_r, s2_dv_im_r;
  logic [cau_pkg::REM_BITS-1:0]         s2_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
    if (en) begin
      s2_div_r    <= (s1_cmd_r == cau_pkg::CMD_DIV);
      s2_ov_r     <= sat_re[cau_pkg::WORD_BITS] | sat_im[cau_pkg::WORD_BITS];
      s2_res_re_r <= sat_re[cau_pkg::WORD_BITS-1:0];
      s2_res_im_r <= sat_im[cau_pkg::WORD_BITS-1:0];
      s2_dv_re_r  <= dv_re;
      s2_dv_im_r  <= dv_im;
      s2_den_r    <= den;
    end
  end

  // stage 3: magnitudes, leading remainder, quotient range check
  logic [cau_pkg::NUM_BITS-1:0]  mag_re, mag_im;
  logic [cau_pkg::FULL_BITS-1:0] full_re, full_im;
  logic [cau_pkg::FULL_BITS-cau_pkg::QUO_BITS-1:0] head_re, head_im;
  logic                          den_zero;
  cau_pkg::lane_t                lane_nxt;
  cau_pkg::lane_t                lane_r;

  always_comb begin
    mag_re   = s2_dv_re_r[cau_pkg::NUM_BITS-1] ? -s2_dv_re_r : s2_dv_re_r;
    mag_im   = s2_dv_im_r[cau_pkg::NUM_BITS-1] ? -s2_dv_im_r : s2_dv_im_r;
    full_re  = cau_pkg::FULL_BITS'(mag_re) << cau_pkg::FRAC_BITS;
    full_im  = cau_pkg::FULL_BITS'(mag_im) << cau_pkg::FRAC_BITS;
    head_re  = full_re[cau_pkg::FULL_BITS-1:cau_pkg::QUO_BITS];
    head_im  = full_im[cau_pkg::FULL_BITS-1:cau_pkg::QUO_BITS];
    den_zero = (s2_den_r == '0);
    lane_nxt.valid  = s2_valid_r;
    lane_nxt.div    = s2_div_r & ~den_zero;
    lane_nxt.dz     = s2_div_r & den_zero;
    lane_nxt.ov     = s2_ov_r;
    lane_nxt.neg_re = s2_dv_re_r[cau_pkg::NUM_BITS-1];
    lane_nxt.neg_im = s2_dv_im_r[cau_pkg::NUM_BITS-1];
    lane_nxt.big_re = (head_re >= s2_den_r);
    lane_nxt.big_im = (head_im >= s2_den_r);
    lane_nxt.den    = s2_den_r;
    lane_nxt.rem_re = cau_pkg::REM_BITS'(head_re);
    lane_nxt.rem_im = cau_pkg::REM_BITS'(head_im);
    lane_nxt.nlo_re = full_re[cau_pkg::QUO_BITS-1:0];
    lane_nxt.nlo_im = full_im[cau_pkg::QUO_BITS-1:0];
    lane_nxt.q_re   = '0;
    lane_nxt.q_im   = '0;
    lane_nxt.res_re = s2_res_re_r;
    lane_nxt.res_im = s2_res_im_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.valid <= 1'b0;
    end else if (en) begin
      lane_r.valid <= lane_nxt.valid;
    end
    if (en) begin
      lane_r.div    <= lane_nxt.div;
      lane_r.dz     <= lane_nxt.dz;
      lane_r.ov     <= lane_nxt.ov;
      lane_r.neg_re <= lane_nxt.neg_re;
      lane_r.neg_im <= lane_nxt.neg_im;
      lane_r.big_re <= lane_nxt.big_re;
      lane_r.big_im <= lane_nxt.big_im;
      lane_r.den    <= lane_nxt.den;
      lane_r.rem_re <= lane_nxt.rem_re;
      lane_r.rem_im <= lane_nxt.rem_im;
      lane_r.nlo_re <= lane_nxt.nlo_re;
      lane_r.nlo_im <= lane_nxt.nlo_im;
      lane_r.q_re   <= lane_nxt.q_re;
      lane_r.q_im   <= lane_nxt.q_im;
      lane_r.res_re <= lane_nxt.res_re;
      lane_r.res_im <= lane_nxt.res_im;
    end
  end

  assign lane_o = lane_r;

endmodule

// ===== design/cau_cell.sv =====
// One restoring-division cell: one quotient bit for both result parts.
module cau_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  cau_pkg::lane_t lane_i,
  output cau_pkg::lane_t lane_o
);

  logic [cau_pkg::REM_BITS:0] t_re, t_im, den_x;
  logic                       ge_re, ge_im;
  cau_pkg::lane_t             lane_nxt;
  cau_pkg::lane_t             lane_r;

  always_comb begin
    den_x = {1'b0, lane_i.den};
    t_re  = {lane_i.rem_re, lane_i.nlo_re[cau_pkg::QUO_BITS-1]};
    t_im  = {lane_i.rem_im, lane_i.nlo_im[cau_pkg::QUO_BITS-1]};
    ge_re = (t_re >= den_x);
    ge_im = (t_im >= den_x);
    lane_nxt        = lane_i;
    lane_nxt.rem_re = ge_re ? cau_pkg::REM_BITS'(t_re - den_x) : t_re[cau_pkg::REM_BITS-1:0];
    lane_nxt.rem_im = ge_im ? cau_pkg::REM_BITS'(t_im - den_x) : t_im[cau_pkg::REM_BITS-1:0];
    lane_nxt.nlo_re = lane_i.nlo_re << 1;
    lane_nxt.nlo_im = lane_i.nlo_im << 1;
    lane_nxt.q_re   = {lane_i.q_re[cau_pkg::QUO_BITS-2:0], ge_re};
    lane_nxt.q_im   = {lane_i.q_im[cau_pkg::QUO_BITS-2:0], ge_im};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.valid <= 1'b0;
    end else if (en) begin
      lane_r.valid <= lane_nxt.valid;
    end
    if (en) begin
      lane_r.div    <= lane_nxt.div;
      lane_r.dz     <= lane_nxt.dz;
      lane_r.ov     <= lane_nxt.ov;
      lane_r.neg_re <= lane_nxt.neg_re;
      lane_r.neg_im <= lane_nxt.neg_im;
      lane_r.big_re <= lane_nxt.big_re;
      lane_r.big_im <= lane_nxt.big_im;
      lane_r.den    <= lane_nxt.den;
      lane_r.rem_re <= lane_nxt.rem_re;
      lane_r.rem_im <= lane_nxt.rem_im;
      lane_r.nlo_re <= lane_nxt.nlo_re;
      lane_r.nlo_im <= lane_nxt.nlo_im;
      lane_r.q_re   <= lane_nxt.q_re;
      lane_r.q_im   <= lane_nxt.q_im;
      lane_r.res_re <= lane_nxt.res_re;
      lane_r.res_im <= lane_nxt.res_im;
    end
  end

  assign lane_o = lane_r;

endmodule

// ===== design/complex_arithmetic_unit_top.sv =====
// Complex fixed-point ALU top level: front stages, division cell chain, output register.
//
// Usage: the in_ch channel carries one beat per operation: a command (add, subtract,
// multiply, divide, conjugate, negate) and two complex Q16.16 operands. The out_ch
// channel returns one beat per input beat, in order: the saturated complex result,
// a divide-by-zero flag and an overflow flag.
// Path: the accepting edge loads the first of three front stages; a beat then passes
// through 32 division cells and one output register before out_ch.valid rises;
// every command takes the same path.
// Throughput: one beat per cycle while out_ch does not stall; the divider is a chain of 32 cells,
// each producing one quotient bit for both parts, so a new operand pair can enter every cycle.
// Stall: when out_ch.ready is low with a result waiting, the whole pipeline holds and
// in_ch.ready drops; no beat is dropped or repeated. While the output register is
// empty or being drained, in_ch.ready stays high.
// Reset: synchronous, active low; all stage valid flags clear, so in-flight beats are
// discarded and out_ch.valid is low after reset.
module complex_arithmetic_unit_top (
  input  logic      clk,
  input  logic      rst_n,
  cau_in_if.sink    in_ch,
  cau_out_if.source out_ch
);

  logic adv;
  cau_pkg::lane_t chain [cau_pkg::DIV_CELLS+1];

  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  cau_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.command),
    .in_a_re  (in_ch.a_re),
    .in_a_im  (in_ch.a_im),
    .in_b_re  (in_ch.b_re),
    .in_b_im  (in_ch.b_im),
    .lane_o   (chain[0])
  );

  for (genvar k = 0; k < cau_pkg::DIV_CELLS; k++) begin : g_cell
    cau_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .lane_i (chain[k]),
      .lane_o (chain[k+1])
    );
  end

  cau_pkg::lane_t                       last;
  logic signed [cau_pkg::SAT_BITS-1:0]  v_re, v_im, lim;
  logic [cau_pkg::WORD_BITS:0]          s_re, s_im;

  always_comb begin
    last = chain[cau_pkg::DIV_CELLS];
    lim  = cau_pkg::SAT_BITS'(1) << cau_pkg::WORD_BITS;
    v_re = last.big_re ? lim : cau_pkg::SAT_BITS'({1'b0, last.q_re});
    v_im = last.big_im ? lim : cau_pkg::SAT_BITS'({1'b0, last.q_im});
    if (last.neg_re) begin
      v_re = -v_re;
    end
    if (last.neg_im) begin
      v_im = -v_im;
    end
    s_re = cau_pkg::sat_word(v_re);
    s_im = cau_pkg::sat_word(v_im);
  end

  logic           out_valid_r;
  cau_pkg::word_t res_re_r, res_im_r;
  logic           dz_r, ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= last.valid;
    end
    if (adv) begin
      dz_r <= last.dz;
      if (last.div) begin
        res_re_r <= s_re[cau_pkg::WORD_BITS-1:0];
        res_im_r <= s_im[cau_pkg::WORD_BITS-1:0];
        ov_r     <= s_re[cau_pkg::WORD_BITS] | s_im[cau_pkg::WORD_BITS];
      end else begin
        res_re_r <= last.res_re;
        res_im_r <= last.res_im;
        ov_r     <= last.ov;
      end
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.res_re   = res_re_r;
  assign out_ch.res_im   = res_im_r;
  assign out_ch.div_zero = dz_r;
  assign out_ch.overflow = ov_r;

  a_dz_no_ov: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.div_zero && out_ch.overflow))
    else $error("div_zero beat also flags overflow");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.div_zero) |-> (out_ch.res_re == '0 && out_ch.res_im == '0))
    else $error("div_zero beat with nonzero result");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(chain[0].valid) && $stable(last.valid))
    else $error("pipeline moved during stall");

  a_lane_excl: assert property (@(posedge clk) disable iff (!rst_n)
    last.valid |-> !(last.div && last.dz))
    else $error("lane marked both divide and zero divisor");

endmodule

// ===== bench/tb_complex_arithmetic_unit_top.sv =====
// Self-checking bench for the complex fixed-point ALU: directed corners and random traffic, in-order result check.
module tb_complex_arithmetic_unit_top;

  typedef struct {
    cau_pkg::cmd_t  cmd;
    cau_pkg::word_t ar, ai, br, bi;
    bit             drain_first;
  } operand_beat_t;

  typedef struct {
    cau_pkg::word_t re, im;
    logic           dz, ov;
  } alu_result_t;

  localparam int WATCHDOG_CYCLES = 5000;
  localparam int TAIL_CYCLES     = 60;
  localparam int RANDOM_BEATS    = 1100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cau_in_if  in_ch ();
  cau_out_if out_ch ();

  complex_arithmetic_unit_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  operand_beat_t pending_beats[$];
  alu_result_t   expected_results[$];
  int            error_count = 0;
  int            idle_cycles = 0;
  int            send_gap = 0;
  int            recv_gap = 0;
  bit            calm_phase = 1'b0;

  function automatic logic signed [127:0] sat_part(input logic signed [127:0] v,
                                                   inout logic ov);
    if (v > 128'sd2147483647) begin
      ov = 1'b1;
      return 128'sd2147483647;
    end else if (v < -128'sd2147483648) begin
      ov = 1'b1;
      return -128'sd2147483648;
    end
    return v;
  endfunction

  function automatic logic signed [127:0] quotient_part(input logic signed [127:0] num,
                                                        input logic [127:0] den);
    logic [127:0] mag;
    logic [127:0] q;
    mag = (num < 0) ? -num : num;
    q   = (mag << cau_pkg::FRAC_BITS) / den;
    return (num < 0) ? -$signed(q) : $signed(q);
  endfunction

  function automatic alu_result_t compute_alu(input operand_beat_t b);
    logic signed [127:0] ar, ai, br, bi, vr, vi;
    logic [127:0]        den;
    alu_result_t         r;
    ar = b.ar; ai = b.ai; br = b.br; bi = b.bi;
    vr = '0; vi = '0;
    r.dz = 1'b0;
    r.ov = 1'b0;
    case (b.cmd)
      cau_pkg::CMD_ADD: begin
        vr = ar + br;
        vi = ai + bi;
      end
      cau_pkg::CMD_SUB: begin
        vr = ar - br;
        vi = ai - bi;
      end
      cau_pkg::CMD_MUL: begin
        vr = (ar * br - ai * bi) >>> cau_pkg::FRAC_BITS;
        vi = (ar * bi + ai * br) >>> cau_pkg::FRAC_BITS;
      end
      cau_pkg::CMD_DIV: begin
        if (br == 0 && bi == 0) begin
          r.dz = 1'b1;
        end else begin
          den = br * br + bi * bi;
          vr  = quotient_part(ar * br + ai * bi, den);
          vi  = quotient_part(ai * br - ar * bi, den);
        end
      end
      cau_pkg::CMD_CONJ: begin
        vr = ar;
        vi = -ai;
      end
      cau_pkg::CMD_NEG: begin
        vr = -ar;
        vi = -ai;
      end
      default: ;
    endcase
    vr = sat_part(vr, r.ov);
    vi = sat_part(vi, r.ov);
    r.re = vr[31:0];
    r.im = vi[31:0];
    return r;
  endfunction

  function automatic cau_pkg::word_t random_word();
    cau_pkg::word_t w;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 6))
          0: w = 32'h7fffffff;
          1: w = 32'h80000000;
          2: w = 32'h0;
          3: w = 32'hffffffff;
          4: w = 32'h1;
          5: w = 32'h00010000;
          default: w = 32'hffff0000;
        endcase
      end
      1, 2, 3: w = $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
      4, 5:    w = $signed($urandom_range(0, 32'h03ffffff)) - 32'sh02000000;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  function automatic cau_pkg::cmd_t random_cmd();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) return cau_pkg::CMD_ADD;
    if (pick < 30) return cau_pkg::CMD_SUB;
    if (pick < 52) return cau_pkg::CMD_MUL;
    if (pick < 80) return cau_pkg::CMD_DIV;
    if (pick < 88) return cau_pkg::CMD_CONJ;
    if (pick < 96) return cau_pkg::CMD_NEG;
    return cau_pkg::cmd_t'($urandom_range(6, 7));
  endfunction

  task automatic queue_beat(input cau_pkg::cmd_t c, input cau_pkg::word_t ar,
                            input cau_pkg::word_t ai, input cau_pkg::word_t br,
                            input cau_pkg::word_t bi, input bit drain);
    operand_beat_t b;
    b.cmd = c; b.ar = ar; b.ai = ai; b.br = br; b.bi = bi;
    b.drain_first = drain;
    pending_beats.push_back(b);
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    error_count++;
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (calm_phase || p < 60) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.command <= cau_pkg::CMD_ADD;
      in_ch.a_re    <= '0;
      in_ch.a_im    <= '0;
      in_ch.b_re    <= '0;
      in_ch.b_im    <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        operand_beat_t cur;
        cur.cmd = in_ch.command; cur.ar = in_ch.a_re; cur.ai = in_ch.a_im;
        cur.br = in_ch.b_re; cur.bi = in_ch.b_im;
        expected_results.push_back(compute_alu(cur));
      end
      if ($urandom_range(0, 199) == 0) calm_phase = !calm_phase;
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_beats.size() > 0 && !(pending_beats[0].drain_first &&
                   (in_ch.valid || expected_results.size() > 0))) begin
        operand_beat_t nb;
        nb = pending_beats.pop_front();
        in_ch.valid   <= 1'b1;
        in_ch.command <= nb.cmd;
        in_ch.a_re    <= nb.ar;
        in_ch.a_im    <= nb.ai;
        in_ch.b_re    <= nb.br;
        in_ch.b_im    <= nb.bi;
        send_gap = pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          error_count++;
          $display("unexpected result beat at %0t", $realtime);
        end else begin
          alu_result_t e;
          e = expected_results.pop_front();
          if (out_ch.res_re !== e.re) report("res_re", out_ch.res_re, e.re);
          if (out_ch.res_im !== e.im) report("res_im", out_ch.res_im, e.im);
          if (out_ch.div_zero !== e.dz) begin
            report("div_zero", 32'(out_ch.div_zero), 32'(e.dz));
          end
          if (out_ch.overflow !== e.ov) begin
            report("overflow", 32'(out_ch.overflow), 32'(e.ov));
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_CYCLES) begin
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.command = cau_pkg::CMD_ADD;
    in_ch.a_re    = '0;
    in_ch.a_im    = '0;
    in_ch.b_re    = '0;
    in_ch.b_im    = '0;
    out_ch.ready  = 1'b0;

    // directed corners
    queue_beat(cau_pkg::CMD_ADD, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
               1'b0);
    queue_beat(cau_pkg::CMD_ADD, 32'h00018000, 32'hfffe8000, 32'h00010000, 32'h00010000,
               1'b0);
    queue_beat(cau_pkg::CMD_SUB, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
               1'b0);
    queue_beat(cau_pkg::CMD_SUB, 32'h0, 32'h0, 32'h80000000, 32'h1, 1'b0);
    queue_beat(cau_pkg::CMD_MUL, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
               1'b0);
    queue_beat(cau_pkg::CMD_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
               1'b0);
    queue_beat(cau_pkg::CMD_MUL, 32'h00010000, 32'h0, 32'h00010000, 32'h0, 1'b0);
    queue_beat(cau_pkg::CMD_MUL, 32'hffffffff, 32'h1, 32'h00000001, 32'hffffffff, 1'b0);
    queue_beat(cau_pkg::CMD_DIV, 32'h00050000, 32'h00030000, 32'h0, 32'h0, 1'b0);
    queue_beat(cau_pkg::CMD_DIV, 32'h80000000, 32'h7fffffff, 32'h0, 32'h0, 1'b0);
    queue_beat(cau_pkg::CMD_DIV, 32'h00030000, 32'hfffd0000, 32'h00010000, 32'h0, 1'b0);
    queue_beat(cau_pkg::CMD_DIV, 32'h7fffffff, 32'h80000000, 32'h00000001, 32'h0, 1'b0);
    queue_beat(cau_pkg::CMD_DIV, 32'hfffe0000, 32'h00010000, 32'h0, 32'h00030000, 1'b0);
    queue_beat(cau_pkg::CMD_DIV, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
               1'b0);
    queue_beat(cau_pkg::CMD_DIV, 32'hffffffff, 32'h0, 32'h7fffffff, 32'h7fffffff, 1'b0);
    queue_beat(cau_pkg::CMD_CONJ, 32'h80000000, 32'h80000000, 32'h0, 32'h0, 1'b0);
    queue_beat(cau_pkg::CMD_CONJ, 32'h7fffffff, 32'h7fffffff, 32'h1, 32'h1, 1'b0);
    queue_beat(cau_pkg::CMD_NEG, 32'h80000000, 32'h7fffffff, 32'h0, 32'h0, 1'b0);
    queue_beat(cau_pkg::CMD_NEG, 32'h00012345, 32'hfffedcba, 32'h0, 32'h0, 1'b0);
    queue_beat(cau_pkg::CMD_ADD, 32'h00020000, 32'h0, 32'h00010000, 32'h0, 1'b0);
    queue_beat(cau_pkg::cmd_t'(6), 32'h7fffffff, 32'h80000000, 32'h0, 32'h0, 1'b0);
    queue_beat(cau_pkg::cmd_t'(7), 32'hdeadbeef, 32'h12345678, 32'h0, 32'h0, 1'b0);

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      cau_pkg::cmd_t  c;
      cau_pkg::word_t br, bi;
      c  = random_cmd();
      br = random_word();
      bi = random_word();
      if (c == cau_pkg::CMD_DIV && $urandom_range(0, 19) == 0) begin
        br = '0;
        bi = '0;
      end else if ($urandom_range(0, 9) == 0) begin
        bi = '0;
      end
      queue_beat(c, random_word(), random_word(), br, bi,
                 (i == 0) || (i == RANDOM_BEATS / 2));
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_beats.size() != 0 || in_ch.valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== complex_arithmetic_unit_top.f =====
design/cau_pkg.sv
design/cau_if.sv
design/cau_front.sv
design/cau_cell.sv
design/complex_arithmetic_unit_top.sv
bench/tb_complex_arithmetic_unit_top.sv
